/* src/mbe_pkg.sv */
package mbe_pkg;

  // Fixed-point format of the point and of z.
  localparam int FRAC_BITS   = 28;
  localparam int DATA_WIDTH  = 32;
  localparam int PROD_WIDTH  = 2 * DATA_WIDTH;

  // Iteration count and colour.
  localparam int COUNT_WIDTH = 16;
  localparam int GRAY_WIDTH  = 24;
  localparam int NUM_WIDTH   = GRAY_WIDTH + COUNT_WIDTH;
  localparam int DIV_CNT_W   = $clog2(NUM_WIDTH);

  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(1000);

  // Register map.
  localparam int ADDR_WIDTH = 3;
  localparam logic REG_LIMIT = 1'b0;

  // Escape bound 4.0 and the saturation limits, all at product width.
  localparam logic signed [PROD_WIDTH-1:0] BOUND =
    PROD_WIDTH'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [PROD_WIDTH-1:0] SAT_MAX =
    PROD_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PROD_WIDTH-1:0] SAT_MIN =
    -PROD_WIDTH'(64'sd1 <<< (DATA_WIDTH - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic div_load;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
    logic div_last;
  } status_t;

endpackage

/* src/mbe_ctrl.sv */
module mbe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mbe_pkg::status_t status,
  output mbe_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done
);

  mbe_pkg::state_t state;
  mbe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        state_next = mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        if (status.escape || status.last) begin
          state_next = mbe_pkg::ST_DIV_LOAD;
        end else begin
          state_next = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_DIV_LOAD: begin
        state_next = mbe_pkg::ST_DIV;
      end
      mbe_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = mbe_pkg::ST_DONE;
        end
      end
      mbe_pkg::ST_DONE: begin
        state_next = mbe_pkg::ST_IDLE;
      end
      default: begin
        state_next = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    busy     = 1'b1;
    done     = 1'b0;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mbe_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      mbe_pkg::ST_UPD: begin
        cmd.upd = !status.escape;
      end
      mbe_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
      end
      mbe_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      mbe_pkg::ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* src/mbe_dpath.sv */
module mbe_dpath (
  input  logic                                  clk,
  input  mbe_pkg::cmd_t                         cmd,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] point_real,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] point_imag,
  input  logic [mbe_pkg::COUNT_WIDTH-1:0]       limit,
  output mbe_pkg::status_t                      status,
  output logic [mbe_pkg::COUNT_WIDTH-1:0]       count,
  output logic [mbe_pkg::GRAY_WIDTH-1:0]        gray
);

  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_re;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] c_im;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] x;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] y;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] p_xx;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] p_yy;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] p_xy;

  logic signed [mbe_pkg::PROD_WIDTH-1:0] xx;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] yy;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] xy2;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] mag;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] nx;
  logic signed [mbe_pkg::PROD_WIDTH-1:0] ny;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] x_next;
  logic signed [mbe_pkg::DATA_WIDTH-1:0] y_next;
  logic [mbe_pkg::COUNT_WIDTH-1:0]       count_inc;

  logic [mbe_pkg::NUM_WIDTH-1:0]   num;
  logic [mbe_pkg::COUNT_WIDTH-1:0] rem;
  logic [mbe_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [mbe_pkg::COUNT_WIDTH:0]   rem_sh;
  logic [mbe_pkg::COUNT_WIDTH:0]   rem_sub;
  logic                            q_bit;

  // Shifted squares and the doubled cross product; each shift is arithmetic.
  always_comb begin
    xx  = p_xx >>> mbe_pkg::FRAC_BITS;
    yy  = p_yy >>> mbe_pkg::FRAC_BITS;
    xy2 = p_xy >>> (mbe_pkg::FRAC_BITS - 1);
    mag = xx + yy;
    nx  = xx - yy + mbe_pkg::PROD_WIDTH'(c_re);
    ny  = xy2 + mbe_pkg::PROD_WIDTH'(c_im);

    if (nx > mbe_pkg::SAT_MAX) begin
      x_next = mbe_pkg::DATA_WIDTH'(mbe_pkg::SAT_MAX);
    end else if (nx < mbe_pkg::SAT_MIN) begin
      x_next = mbe_pkg::DATA_WIDTH'(mbe_pkg::SAT_MIN);
    end else begin
      x_next = nx[mbe_pkg::DATA_WIDTH-1:0];
    end

    if (ny > mbe_pkg::SAT_MAX) begin
      y_next = mbe_pkg::DATA_WIDTH'(mbe_pkg::SAT_MAX);
    end else if (ny < mbe_pkg::SAT_MIN) begin
      y_next = mbe_pkg::DATA_WIDTH'(mbe_pkg::SAT_MIN);
    end else begin
      y_next = ny[mbe_pkg::DATA_WIDTH-1:0];
    end
  end

  assign count_inc     = count + mbe_pkg::COUNT_WIDTH'(1);
  assign status.escape = (mag > mbe_pkg::BOUND);
  assign status.last   = (count_inc == limit);
  assign status.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re  <= point_real;
      c_im  <= point_imag;
      x     <= point_real;
      y     <= point_imag;
      count <= '0;
    end else if (cmd.upd) begin
      x     <= x_next;
      y     <= y_next;
      count <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_xx <= x * x;
      p_yy <= y * y;
      p_xy <= x * y;
    end
  end

  // Restoring divider, one quotient bit a cycle. The dividend is
  // count * 0xFFFFFF, formed as (count << 24) - count.
  assign rem_sh  = {rem, num[mbe_pkg::NUM_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, limit};
  assign q_bit   = (rem_sh >= {1'b0, limit});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num     <= {count, mbe_pkg::GRAY_WIDTH'(0)} - mbe_pkg::NUM_WIDTH'(count);
      rem     <= '0;
      div_cnt <= mbe_pkg::DIV_CNT_W'(mbe_pkg::NUM_WIDTH - 1);
    end else if (cmd.div_step) begin
      num     <= {num[mbe_pkg::NUM_WIDTH-2:0], q_bit};
      rem     <= q_bit ? rem_sub[mbe_pkg::COUNT_WIDTH-1:0]
                       : rem_sh[mbe_pkg::COUNT_WIDTH-1:0];
      div_cnt <= div_cnt - mbe_pkg::DIV_CNT_W'(1);
    end
  end

  assign gray = num[mbe_pkg::GRAY_WIDTH-1:0];

endmodule

/* src/mandelbrot_escape_time.sv */
// From the accepting edge the controller runs a multiply and an update step per escape test
// (the final count, plus one when the point escaped), then loads and runs the one-bit-a-cycle
// colour divider, then gives the done strobe. A new point is taken only once the block is idle
// again after that strobe, as the single multiply-then-update iteration loop serves one point
// at a time. Reset (rst, synchronous) returns the controller to idle and the iteration limit to
// 1000. Results cannot be stalled: each one is valid in the single cycle in which done is high.
module mandelbrot_escape_time (
  input  logic                                  clk,
  input  logic                                  rst,
  // Command channel.
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] point_real,
  input  logic signed [mbe_pkg::DATA_WIDTH-1:0] point_imag,
  // Result channel.
  output logic                                  done,
  output logic [mbe_pkg::COUNT_WIDTH-1:0]       iteration_count,
  output logic                                  hit_limit,
  output logic [mbe_pkg::GRAY_WIDTH-1:0]        gray_color,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mbe_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic [mbe_pkg::COUNT_WIDTH-1:0] iteration_limit;
  logic                            cfg_write;
  mbe_pkg::cmd_t                   cmd;
  mbe_pkg::status_t                status;

  // The register port never inserts wait states. A transfer is decoded on
  // the word index alone, so only the first word holds a register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // The limit is held at one or more: a write of zero stores one. It is only to be rewritten
  // while the block is idle (the block does not enforce this), so the datapath reads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= mbe_pkg::LIMIT_RESET;
    end else if (cfg_write && (paddr[2] == mbe_pkg::REG_LIMIT)) begin
      if (pwdata[mbe_pkg::COUNT_WIDTH-1:0] == '0) begin
        iteration_limit <= mbe_pkg::COUNT_WIDTH'(1);
      end else begin
        iteration_limit <= pwdata[mbe_pkg::COUNT_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mbe_pkg::REG_LIMIT) begin
      prdata = 32'(iteration_limit);
    end
  end

  // The controller sequences a load, then alternating multiply and update
  // cycles until the point escapes or reaches the limit, then the divider.
  mbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mbe_dpath u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .point_real (point_real),
    .point_imag (point_imag),
    .limit      (iteration_limit),
    .status     (status),
    .count      (iteration_count),
    .gray       (gray_color)
  );

  // The count never passes the limit, so equality marks a point that ran out.
  assign hit_limit = (iteration_count == iteration_limit);

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted point did not make the block busy");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block did not return to idle after a result transfer");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result transfer outside a busy period");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (iteration_count <= iteration_limit))
    else $error("iteration count exceeds the limit");

  a_full_gray: assert property (@(posedge clk) disable iff (rst)
    (done && hit_limit) |-> (gray_color == {mbe_pkg::GRAY_WIDTH{1'b1}}))
    else $error("point at the limit did not give full white");
`endif

endmodule

/* bench/mbe_escape_checker.sv */
`timescale 1ns / 1ps

// Watches the command, result and register channels of the escape-time block, works out the
// expected result of every accepted point and compares each result strobe with the oldest one.
module mbe_escape_checker
  import mbe_pkg::*;
#(
  parameter logic [ADDR_WIDTH-1:0] LIMIT_ADDR = '0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] point_real,
  input  logic signed [DATA_WIDTH-1:0] point_imag,
  input  logic                         done,
  input  logic [COUNT_WIDTH-1:0]       iteration_count,
  input  logic                         hit_limit,
  input  logic [GRAY_WIDTH-1:0]        gray_color,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_WIDTH-1:0]        paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  input  logic                         flush,
  output int                           pending_points,
  output int                           mismatches
);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   hit;
    logic [GRAY_WIDTH-1:0]  gray;
  } escape_t;

  escape_t                expected_escapes[$];
  logic [COUNT_WIDTH-1:0] limit_copy;
  logic                   flushed;

  // Iterates z = z*z + c from z = c until |z|^2 passes 4.0 or the limit is reached.
  function automatic escape_t predict_escape(input logic signed [DATA_WIDTH-1:0] c_re,
                                             input logic signed [DATA_WIDTH-1:0] c_im,
                                             input logic [COUNT_WIDTH-1:0] lim);
    logic signed [PROD_WIDTH-1:0] re_ext, im_ext, x, y, sq_re, sq_im, cross2, nx, ny;
    logic [63:0]                  scaled;
    int unsigned                  n;
    bit                           escaped;
    escape_t                      res;
    re_ext  = c_re;
    im_ext  = c_im;
    x       = re_ext;
    y       = im_ext;
    n       = 0;
    escaped = 1'b0;
    while (n < lim && !escaped) begin
      sq_re = (x * x) >>> FRAC_BITS;
      sq_im = (y * y) >>> FRAC_BITS;
      if (sq_re + sq_im > BOUND) begin
        escaped = 1'b1;
      end else begin
        cross2 = (x * y) >>> (FRAC_BITS - 1);
        nx = sq_re - sq_im + re_ext;
        ny = cross2 + im_ext;
        x  = (nx > SAT_MAX) ? SAT_MAX : (nx < SAT_MIN) ? SAT_MIN : nx;
        y  = (ny > SAT_MAX) ? SAT_MAX : (ny < SAT_MIN) ? SAT_MIN : ny;
        n++;
      end
    end
    scaled    = (64'hFF_FFFF * 64'(n)) / 64'(lim);
    res.count = n[COUNT_WIDTH-1:0];
    res.hit   = (n == lim);
    res.gray  = scaled[GRAY_WIDTH-1:0];
    return res;
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    escape_t want;
    if (rst) begin
      expected_escapes.delete();
      limit_copy     = LIMIT_RESET;
      pending_points = 0;
      mismatches     = 0;
      flushed        = 1'b0;
    end else begin
      if (psel && penable && pready && paddr == LIMIT_ADDR) begin
        if (pwrite) begin
          limit_copy = (pwdata[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
                                                       : pwdata[COUNT_WIDTH-1:0];
        end else if (prdata !== 32'(limit_copy)) begin
          report_mismatch("limit read-back", 64'(prdata), 64'(limit_copy));
        end
      end
      if (start && !busy) begin
        expected_escapes.push_back(predict_escape(point_real, point_imag, limit_copy));
      end
      if (done) begin
        if (expected_escapes.size() == 0) begin
          report_mismatch("result with nothing outstanding",
                          64'({iteration_count, hit_limit, gray_color}), 64'(0));
        end else begin
          want = expected_escapes.pop_front();
          if (iteration_count !== want.count)
            report_mismatch("iteration_count", 64'(iteration_count), 64'(want.count));
          if (hit_limit !== want.hit)
            report_mismatch("hit_limit", 64'(hit_limit), 64'(want.hit));
          if (gray_color !== want.gray)
            report_mismatch("gray_color", 64'(gray_color), 64'(want.gray));
        end
      end
      if (flush && !flushed) begin
        flushed = 1'b1;
        if (expected_escapes.size() != 0)
          report_mismatch("results never delivered", 64'(0), 64'(expected_escapes.size()));
      end
      pending_points = expected_escapes.size();
    end
  end

endmodule

/* bench/tb_mandelbrot_escape_time.sv */
`timescale 1ns / 1ps

// Top of the escape-time bench. It only makes stimulus and gives the verdict: the checker
// instance beside the block predicts every result and counts the mismatches.
module tb_mandelbrot_escape_time;
  import mbe_pkg::*;

  // The limit register is the first in the map, so it sits at byte address zero.
  localparam logic [ADDR_WIDTH-1:0] LIMIT_ADDR = ADDR_WIDTH'(4 * int'(REG_LIMIT));

  // A few handy values in the Q4.28 format of the point.
  localparam int FIX_ONE   = 32'h1000_0000;
  localparam int FIX_TWO   = 32'h2000_0000;
  localparam int COORD_MAX = 32'sh7FFF_FFFF;
  localparam int COORD_MIN = 32'sh8000_0000;

  // The slowest legal point is one that runs to the limit at its top, and this leaves a few times
  // its run before a silent block is declared dead.
  localparam int WATCHDOG_LIMIT = 500_000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_POINTS   = 40;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] point_real;
  logic signed [DATA_WIDTH-1:0] point_imag;
  logic                         done;
  logic [COUNT_WIDTH-1:0]       iteration_count;
  logic                         hit_limit;
  logic [GRAY_WIDTH-1:0]        gray_color;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ADDR_WIDTH-1:0]        paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         flush;
  int                           pending_points;
  int                           mismatches;
  int                           quiet_cycles;

  mandelbrot_escape_time dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .point_real      (point_real),
    .point_imag      (point_imag),
    .done            (done),
    .iteration_count (iteration_count),
    .hit_limit       (hit_limit),
    .gray_color      (gray_color),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  mbe_escape_checker #(
    .LIMIT_ADDR (LIMIT_ADDR)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .point_real      (point_real),
    .point_imag      (point_imag),
    .done            (done),
    .iteration_count (iteration_count),
    .hit_limit       (hit_limit),
    .gray_color      (gray_color),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .flush           (flush),
    .pending_points  (pending_points),
    .mismatches      (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog restarts whenever a point or a result is transferred, or the register port
  // is in use. Anything else for too long means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents a point and holds it until the block takes it. The busy value read just after
  // the edge is the one the block saw at that edge, because outputs change only in the
  // nonblocking region.
  task send_point(input logic signed [DATA_WIDTH-1:0] re, input logic signed [DATA_WIDTH-1:0] im);
    start      <= 1'b1;
    point_real <= re;
    point_imag <= im;
    do @(posedge clk); while (busy);
  endtask

  // Leaves start low for a random spell after a transfer. Most spells are short, a few are
  // long, and in a steady phase there are none, so that points follow one another back to
  // back and the next one is waiting while the block is still on the current one.
  task idle_gap(input bit steady);
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    if (steady || roll < 45) begin
      span = 0;
    end else if (roll < 90) begin
      span = $urandom_range(1, 4);
    end else begin
      span = $urandom_range(20, 150);
    end
    if (span > 0) begin
      start <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding result has come back. The first edge lets
  // the checker take note of a point transferred at the edge on which this task was called.
  task wait_drained;
    start <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
  endtask

  // One register transfer: a setup phase, then an access phase that lasts until pready, then
  // an idle phase before the port may be used again.
  task apb_transfer(input bit is_write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= LIMIT_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The limit is only changed with the block idle, and every write is read back.
  task set_limit(input logic [31:0] data);
    wait_drained();
    apb_transfer(1'b1, data);
    apb_transfer(1'b0, 32'h0);
  endtask

  // Random points. Most lie in the box around the set, where orbits last a while and the
  // counts spread out. Some sit right on the escape circle along the real axis, where the
  // bound comparison is decided by the last few bits, and the rest are raw 32-bit noise,
  // which nearly always escapes at once but drives every bit of both ports.
  task random_point(output logic signed [DATA_WIDTH-1:0] re,
                    output logic signed [DATA_WIDTH-1:0] im);
    int roll;
    int nudge;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      re = $urandom;
      im = $urandom;
    end else if (roll < 30) begin
      nudge = int'($urandom_range(0, 16)) - 8;
      re    = DATA_WIDTH'(($urandom_range(0, 1) ? FIX_TWO : -FIX_TWO) + nudge);
      im    = DATA_WIDTH'(int'($urandom_range(0, 16)) - 8);
    end else begin
      re = DATA_WIDTH'(int'($urandom_range(0, 32'h2800_0000)) - FIX_TWO);
      im = DATA_WIDTH'(int'($urandom_range(0, 32'h2800_0000)) - 32'h1400_0000);
    end
  endtask

  initial begin
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic [COUNT_WIDTH-1:0]       lim;
    int                           roll;
    bit                           steady;

    rst        <= 1'b1;
    start      <= 1'b0;
    point_real <= '0;
    point_imag <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    flush      <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The limit should come out of reset at 1000.
    apb_transfer(1'b0, 32'h0);

    // Directed points at the reset limit. The origin and minus two stay bounded and so run
    // to the limit; minus two sits exactly on the circle on every iteration. Two corners of
    // the range and a point on its lower edge lie far outside and must give a count of zero. Plus
    // two and plus and minus two i pass the first test on the bound and escape on the second. The
    // last three are a slow escape just past the cusp, a period-two point and a slow escape near the neck.
    send_point(0, 0);
    idle_gap(1'b0);
    send_point(COORD_MAX, COORD_MAX);
    idle_gap(1'b0);
    send_point(COORD_MIN, COORD_MIN);
    idle_gap(1'b0);
    send_point(0, COORD_MIN);
    idle_gap(1'b0);
    send_point(-FIX_TWO, 0);
    idle_gap(1'b0);
    send_point(FIX_TWO, 0);
    idle_gap(1'b0);
    send_point(0, FIX_TWO);
    idle_gap(1'b0);
    send_point(0, -FIX_TWO);
    idle_gap(1'b0);
    send_point(32'sh0410_0000, 0);
    idle_gap(1'b0);
    send_point(-FIX_ONE, 0);
    idle_gap(1'b0);
    send_point(-32'sh0C00_0000, 32'sh0199_9999);

    // A limit of one. Plus two passes the only test on the bound allowed, so it reaches the
    // limit, and the colour of a full count is white.
    set_limit(32'h0000_0001);
    send_point(0, 0);
    idle_gap(1'b0);
    send_point(FIX_TWO, 0);
    idle_gap(1'b0);
    send_point(COORD_MAX, COORD_MAX);

    // Zero in the low half must be held as one, whatever the upper bits of the data.
    set_limit(32'hFFFF_0000);
    send_point(0, 0);
    set_limit(32'h0000_0000);
    send_point(-FIX_ONE, 0);

    // The largest limit. The origin runs the full 65535 iterations; only three points are spent
    // here, since each bounded one runs every one of those iterations.
    set_limit(32'h0000_FFFF);
    send_point(0, 0);
    idle_gap(1'b0);
    send_point(32'sh0410_0000, 0);
    idle_gap(1'b0);
    send_point(COORD_MIN, COORD_MAX);

    // Random phases, each with its own limit. Small limits keep bounded points cheap and make
    // escapes on the last allowed iteration common; now and then a larger one stretches the
    // counts. The upper half of the write data is random and must be ignored.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        lim = COUNT_WIDTH'($urandom_range(1, 40));
      end else if (roll < 85) begin
        lim = COUNT_WIDTH'($urandom_range(41, 300));
      end else begin
        lim = COUNT_WIDTH'($urandom_range(301, 1200));
      end
      set_limit({16'($urandom), lim});
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        random_point(re, im);
        send_point(re, im);
        // Occasionally hold back until the block has handed over everything.
        if ($urandom_range(0, 49) == 0) begin
          wait_drained();
        end else begin
          idle_gap(steady);
        end
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    flush <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mbe_pkg.sv
src/mbe_ctrl.sv
src/mbe_dpath.sv
src/mandelbrot_escape_time.sv
bench/mbe_escape_checker.sv
bench/tb_mandelbrot_escape_time.sv
